/* rtl/sorted_table_binary_search_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table search core
// Shared property shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define STBS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define STBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define STBS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/stbs_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted table search package
// Sizes, item codes and controller states shared across the block.
// ----------------------------------------------------------------------------
package stbs_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int WORD_W      = 32;
   localparam int POS_W       = 8;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // item codes on the mode field
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EMIT
   } state_type;

endpackage

/* rtl/stbs_channels.sv */
// ----------------------------------------------------------------------------
// Sorted table search channels
// Valid/ready request and response interfaces with their payload.
// ----------------------------------------------------------------------------
interface stbs_req_if;
   logic                               valid;
   logic                               ready;
   logic                               mode;
   logic signed [stbs_pkg::WORD_W-1:0] value;
   logic                               last;

   modport source (output valid, output mode, output value, output last, input ready);
   modport sink   (input valid, input mode, input value, input last, output ready);
endinterface

interface stbs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [stbs_pkg::POS_W-1:0]  position;

   modport source (output valid, output found, output position, input ready);
   modport sink   (input valid, input found, input position, output ready);
endinterface

/* rtl/stbs_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module stbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sorted_table_binary_search_core.sv */
// ----------------------------------------------------------------------------
// Sorted table binary search core
// Loads a table of signed words into on-chip RAM and answers key lookups by
// binary search. A load item (mode 0) appends one word and gives no
// response; last closes the table so the next load restarts at entry 0,
// and words past the table depth are dropped. A search item (mode 1) gives
// one response: found and the matching index, or found = 0 and index 0. A
// search makes at most log2(depth) + 1 probes (9 for 256 entries), one
// probe per cycle through the single RAM read port, then moves its outcome
// into the response register once that is free. Input ready returns in the
// same cycle as the registered response, even while it still waits on the
// response channel, so a search holds the input from acceptance until its
// response is registered. Table entries hold no reset value; a search only
// ever reads entries written by the current load.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core (
   input  logic              clock,
   input  logic              reset,
   stbs_req_if.sink          req_chan,
   stbs_rsp_if.source        rsp_chan
);

   // controller state
   stbs_pkg::state_type              state_ff, state_in;

   // table bookkeeping
   logic [stbs_pkg::CNT_W-1:0]        count_ff, count_in;
   logic                              closed_ff, closed_in;

   // search window: left bound and exclusive upper bound (right + 1)
   logic [stbs_pkg::CNT_W-1:0]        left_ff, left_in;
   logic [stbs_pkg::CNT_W-1:0]        hi_ff, hi_in;
   logic [stbs_pkg::ADDR_W-1:0]       mid_ff, mid_in;
   logic signed [stbs_pkg::WORD_W-1:0] key_ff, key_in;

   // search outcome, held until the response slot frees up
   logic                              found_ff, found_in;
   logic [stbs_pkg::POS_W-1:0]        pos_ff, pos_in;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic [stbs_pkg::POS_W-1:0]        rsp_pos_ff, rsp_pos_in;

   // RAM port signals
   logic                              wr_en;
   logic [stbs_pkg::ADDR_W-1:0]       wr_addr;
   logic                              rd_en;
   logic [stbs_pkg::ADDR_W-1:0]       rd_addr;
   logic [stbs_pkg::WORD_W-1:0]       rd_data;

   // next-window datapath
   logic [stbs_pkg::CNT_W-1:0]        load_base;
   logic [stbs_pkg::CNT_W-1:0]        nxt_left;
   logic [stbs_pkg::CNT_W-1:0]        nxt_hi;
   logic [stbs_pkg::CNT_W:0]          mid_sum;
   logic                              probe_eq;
   logic                              probe_lt;

   stbs_ram #(
      .WIDTH (stbs_pkg::WORD_W),
      .DEPTH (stbs_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Compare the probed word (valid while searching) against the key.
   assign probe_eq = ($signed(rd_data) == key_ff);
   assign probe_lt = ($signed(rd_data) < key_ff);

   // A load after a closed table restarts at entry 0.
   assign load_base = closed_ff ? '0 : count_ff;

   // Next window: the initial window [0, count) on acceptance, otherwise the
   // window narrowed by the current probe. Below the key: left = mid + 1.
   // Above the key: right = mid - 1, i.e. exclusive bound = mid.
   always_comb begin
      if (state_ff == stbs_pkg::ST_SEARCH) begin
         nxt_left = probe_lt ? (stbs_pkg::CNT_W'(mid_ff) + 1'b1) : left_ff;
         nxt_hi   = probe_lt ? hi_ff : stbs_pkg::CNT_W'(mid_ff);
      end else begin
         nxt_left = '0;
         nxt_hi   = count_ff;
      end
   end

   // Midpoint (left + right) / 2 with right = hi - 1, rounded down.
   assign mid_sum = {1'b0, nxt_left} + {1'b0, nxt_hi} - (stbs_pkg::CNT_W+1)'(1);
   assign rd_addr = mid_sum[stbs_pkg::ADDR_W:1];
   assign wr_addr = load_base[stbs_pkg::ADDR_W-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      closed_in    = closed_ff;
      left_in      = left_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      // drop the response once it is taken
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      req_chan.ready = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      unique case (state_ff)
         stbs_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               if (req_chan.mode == stbs_pkg::MODE_LOAD) begin
                  // append the word unless the table is full
                  if (load_base < stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH)) begin
                     wr_en    = 1'b1;
                     count_in = load_base + 1'b1;
                  end else begin
                     count_in = load_base;
                  end
                  closed_in = req_chan.last;
               end else begin
                  key_in   = req_chan.value;
                  left_in  = nxt_left;
                  hi_in    = nxt_hi;
                  found_in = 1'b0;
                  pos_in   = '0;
                  if (count_ff == '0) begin
                     // empty table: answer not found at once
                     state_in = stbs_pkg::ST_EMIT;
                  end else begin
                     rd_en    = 1'b1;
                     mid_in   = rd_addr;
                     state_in = stbs_pkg::ST_SEARCH;
                  end
               end
            end
         end

         stbs_pkg::ST_SEARCH: begin
            if (probe_eq) begin
               found_in = 1'b1;
               pos_in   = stbs_pkg::POS_W'(mid_ff);
               state_in = stbs_pkg::ST_EMIT;
            end else if (nxt_left < nxt_hi) begin
               // window still open: issue the next probe
               rd_en   = 1'b1;
               mid_in  = rd_addr;
               left_in = nxt_left;
               hi_in   = nxt_hi;
            end else begin
               state_in = stbs_pkg::ST_EMIT;
            end
         end

         stbs_pkg::ST_EMIT: begin
            // hold the outcome until the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_pos_in   = pos_ff;
               state_in     = stbs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = stbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         closed_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      found_ff     <= found_in;
      pos_ff       <= pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.found    = rsp_found_ff;
   assign rsp_chan.position = rsp_pos_ff;

endmodule

/* rtl/sorted_table_binary_search_core_checker.sv */
// ----------------------------------------------------------------------------
// Sorted table search port checker
// Watches the top-level ports and flags behavior the core must never show.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_core_macros.svh"

module sorted_table_binary_search_core_props (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_mode,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_found,
   input logic [stbs_pkg::POS_W-1:0] rsp_position
);

   logic                       load_taken;
   logic                       search_taken;
   logic                       rsp_stall;
   logic                       rsp_miss;
   logic [stbs_pkg::POS_W:0]   rsp_item;

   assign load_taken   = req_valid && req_ready && (req_mode == stbs_pkg::MODE_LOAD);
   assign search_taken = req_valid && req_ready && (req_mode == stbs_pkg::MODE_SEARCH);
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_miss     = rsp_valid && !rsp_found;
   assign rsp_item     = {rsp_found, rsp_position};

   // a stalled response holds
   `STBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_item), "held item changed")

   // a miss reports index zero
   `STBS_ASSERT_IMPLY(a_miss_pos, clock, reset, rsp_miss, rsp_position == '0, "miss with nonzero index")

   // a load never produces a response
   `STBS_ASSERT_NEXT(a_load_quiet, clock, reset, load_taken, !$rose(rsp_valid), "item after load")

   // a search occupies the core for at least the next cycle
   `STBS_ASSERT_NEXT(a_search_busy, clock, reset, search_taken, !req_ready, "ready after search")

   // no response straight out of reset
   `STBS_ASSERT_NEXT_ALWAYS(a_reset_clear, clock, reset, !rsp_valid, "valid after reset")

endmodule

bind sorted_table_binary_search_core sorted_table_binary_search_core_props u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_mode     (req_chan.mode),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_found    (rsp_chan.found),
   .rsp_position (rsp_chan.position)
);
